>>> src/u2l_pkg.sv
// Shared types, constants and decode helpers for the UTF-8 to Latin-1 decoder.
`timescale 1ns / 1ps

package u2l_pkg;

  // Result queue sizing
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Special triple tracking: nothing, E2, E2 80, E2 82
  localparam logic [1:0] SM_NONE   = 2'd0;
  localparam logic [1:0] SM_E2     = 2'd1;
  localparam logic [1:0] SM_E2_80  = 2'd2;
  localparam logic [1:0] SM_E2_82  = 2'd3;

  localparam logic [7:0] REPL_RESET    = 8'h5F;
  localparam logic [7:0] LEAD_E2       = 8'hE2;
  localparam logic [7:0] CONT_80       = 8'h80;
  localparam logic [7:0] CONT_82       = 8'h82;
  localparam logic [7:0] CONT_9C       = 8'h9C;
  localparam logic [7:0] CONT_9D       = 8'h9D;
  localparam logic [7:0] CONT_99       = 8'h99;
  localparam logic [7:0] CONT_AC       = 8'hAC;
  localparam logic [7:0] CHAR_LDQUO    = 8'h93;
  localparam logic [7:0] CHAR_RDQUO    = 8'h94;
  localparam logic [7:0] CHAR_RSQUO    = 8'h92;
  localparam logic [7:0] CHAR_CURRENCY = 8'hA4;

  localparam int unsigned ACC_W = 31;

  typedef struct packed {
    logic       end_of_text;
    logic       last_in_run;
    logic [7:0] out_char;
  } result_t;

  // Sequence length from the lead byte; zero marks a stray continuation
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    priority if (b[7] == 1'b0)       len = 3'd1;
    else if (b[7:6] == 2'b10)        len = 3'd0;
    else if (b[7:5] == 3'b110)       len = 3'd2;
    else if (b[7:4] == 4'b1110)      len = 3'd3;
    else if (b[7:3] == 5'b11110)     len = 3'd4;
    else if (b[7:2] == 6'b111110)    len = 3'd5;
    else                             len = 3'd6;
    return len;
  endfunction

  function automatic logic [7:0] lead_mask(input logic [2:0] len);
    logic [7:0] m;
    unique case (len)
      3'd1:    m = 8'h7F;
      3'd2:    m = 8'h1F;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h03;
      3'd6:    m = 8'h01;
      default: m = 8'h3F;
    endcase
    return m;
  endfunction

  // Values above 255 turn into the replacement character
  function automatic logic [7:0] plain_char(input logic [ACC_W-1:0] acc,
                                            input logic [7:0] repl);
    return (acc[ACC_W-1:8] == '0) ? acc[7:0] : repl;
  endfunction

endpackage

>>> src/u2l_out_queue.sv
// Small result queue that takes up to two results per cycle and hands out one.
`timescale 1ns / 1ps

module u2l_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_cnt_i,
  input  u2l_pkg::result_t  push0_i,
  input  u2l_pkg::result_t  push1_i,
  input  logic              pop_i,
  output u2l_pkg::result_t  head_o,
  output logic              not_empty_o,
  output logic              room_o
);

  localparam int unsigned PW = u2l_pkg::QPTR_W;
  localparam int unsigned CW = u2l_pkg::QCNT_W;

  u2l_pkg::result_t mem_q [u2l_pkg::QDEPTH];

  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] count_q, count_d;

  assign wr_d    = wr_q + PW'(push_cnt_i);
  assign rd_d    = rd_q + PW'(pop_i);
  assign count_d = count_q + CW'(push_cnt_i) - CW'(pop_i);

  assign head_o      = mem_q[rd_q];
  assign not_empty_o = (count_q != '0);
  // Room for the worst case of two results from one request
  assign room_o      = (count_q <= CW'(u2l_pkg::QDEPTH - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_q + PW'(1)] <= push1_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(u2l_pkg::QDEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> (count_q + CW'(push_cnt_i) <= CW'(u2l_pkg::QDEPTH) + CW'(pop_i)))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("result queue underflow");

endmodule

>>> src/utf8_to_latin1_decoder.sv
// Top level: UTF-8 byte stream in, Latin-1 character stream out.
// Each result is registered in the result queue before it is offered on the master side.
// Throughput: one byte per cycle while the result queue has room; the decode is one pass of logic per byte.
// Bytes that give two results hand out two characters on the master side; the four-entry result
// queue drops s_axis_tready_o while it holds more than two results.
// Reset clears the decode state and the queue; the replacement char resets to 0x5F.
`timescale 1ns / 1ps

module utf8_to_latin1_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write: replacement_char
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_wdata_i,
  // Input bytes
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // text_end
  // Output characters
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic       m_axis_tuser_o,   // last_in_run
  output logic       m_axis_tlast_o    // end_of_text
);

  localparam int unsigned AW = u2l_pkg::ACC_W;

  logic [7:0]    repl_q;
  logic [AW-1:0] acc_q, acc_d;
  logic [2:0]    bl_q, bl_d;
  logic          pend_q, pend_d;
  logic [1:0]    sm_q, sm_d;

  logic [7:0]    in_byte;
  logic          text_end;
  logic          accept;
  logic          take_cont;
  logic [AW-1:0] acc_sh;
  logic [2:0]    bl_dec;
  logic [1:0]    sm_step;
  logic [2:0]    lead_len;
  logic [7:0]    lead_acc;
  logic [2:0]    lead_bl;
  logic [7:0]    cont_char;
  logic [1:0]    n_res;
  logic [1:0]    push_cnt;

  u2l_pkg::result_t res0, res1, head;
  logic q_not_empty, q_room;

  assign in_byte  = s_axis_tdata_i;
  assign text_end = s_axis_tlast_i;
  assign accept   = s_axis_tvalid_i & s_axis_tready_o;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = q_room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= u2l_pkg::REPL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      repl_q <= cfg_wdata_i;
    end
  end

  assign take_cont = pend_q && (in_byte[7:6] == 2'b10);
  assign acc_sh    = {acc_q[AW-7:0], in_byte[5:0]};
  assign bl_dec    = bl_q - 3'd1;
  assign lead_len  = u2l_pkg::lead_length(in_byte);
  assign lead_acc  = in_byte & u2l_pkg::lead_mask(lead_len);
  assign lead_bl   = (lead_len == 3'd0) ? 3'd4 : lead_len - 3'd1;

  always_comb begin
    sm_step = u2l_pkg::SM_NONE;
    if (sm_q == u2l_pkg::SM_E2) begin
      if (in_byte == u2l_pkg::CONT_80)      sm_step = u2l_pkg::SM_E2_80;
      else if (in_byte == u2l_pkg::CONT_82) sm_step = u2l_pkg::SM_E2_82;
      else                                  sm_step = u2l_pkg::SM_NONE;
    end
  end

  // Complete special triples override the plain value
  always_comb begin
    priority if (sm_q == u2l_pkg::SM_E2_80 && in_byte == u2l_pkg::CONT_9C)
      cont_char = u2l_pkg::CHAR_LDQUO;
    else if (sm_q == u2l_pkg::SM_E2_80 && in_byte == u2l_pkg::CONT_9D)
      cont_char = u2l_pkg::CHAR_RDQUO;
    else if (sm_q == u2l_pkg::SM_E2_80 && in_byte == u2l_pkg::CONT_99)
      cont_char = u2l_pkg::CHAR_RSQUO;
    else if (sm_q == u2l_pkg::SM_E2_82 && in_byte == u2l_pkg::CONT_AC)
      cont_char = u2l_pkg::CHAR_CURRENCY;
    else
      cont_char = u2l_pkg::plain_char(acc_sh, repl_q);
  end

  always_comb begin
    acc_d  = acc_q;
    bl_d   = bl_q;
    pend_d = pend_q;
    sm_d   = sm_q;
    res0   = '0;
    res1   = '0;
    n_res  = 2'd0;
    if (take_cont) begin
      acc_d  = acc_sh;
      bl_d   = bl_dec;
      sm_d   = sm_step;
      pend_d = 1'b1;
      if (bl_dec == 3'd0) begin
        res0.out_char = cont_char;
        n_res         = 2'd1;
        acc_d         = '0;
        pend_d        = 1'b0;
        sm_d          = u2l_pkg::SM_NONE;
      end else if (text_end) begin
        res0.out_char = u2l_pkg::plain_char(acc_sh, repl_q);
        n_res         = 2'd1;
      end
    end else begin
      // Close the pending character, then start a new one from this lead
      if (pend_q) begin
        res0.out_char = u2l_pkg::plain_char(acc_q, repl_q);
        n_res         = 2'd1;
      end
      acc_d  = AW'(lead_acc);
      bl_d   = lead_bl;
      pend_d = 1'b1;
      sm_d   = (in_byte == u2l_pkg::LEAD_E2) ? u2l_pkg::SM_E2 : u2l_pkg::SM_NONE;
      if (lead_bl == 3'd0 || text_end) begin
        if (n_res == 2'd0) begin
          res0.out_char = lead_acc;
        end else begin
          res1.out_char = lead_acc;
        end
        n_res = n_res + 2'd1;
        if (lead_bl == 3'd0) begin
          acc_d  = '0;
          pend_d = 1'b0;
          sm_d   = u2l_pkg::SM_NONE;
        end
      end
    end
    if (text_end) begin
      acc_d  = '0;
      bl_d   = 3'd0;
      pend_d = 1'b0;
      sm_d   = u2l_pkg::SM_NONE;
    end
    // Tag the final result of this request
    if (n_res == 2'd1) begin
      res0.last_in_run = 1'b1;
      res0.end_of_text = text_end;
    end else if (n_res == 2'd2) begin
      res1.last_in_run = 1'b1;
      res1.end_of_text = text_end;
    end
  end

  assign push_cnt = accept ? n_res : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      bl_q   <= 3'd0;
      pend_q <= 1'b0;
      sm_q   <= u2l_pkg::SM_NONE;
    end else if (accept) begin
      acc_q  <= acc_d;
      bl_q   <= bl_d;
      pend_q <= pend_d;
      sm_q   <= sm_d;
    end
  end

  u2l_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .pop_i       (m_axis_tvalid_o & m_axis_tready_i),
    .head_o      (head),
    .not_empty_o (q_not_empty),
    .room_o      (q_room)
  );

  assign m_axis_tvalid_o = q_not_empty;
  assign m_axis_tdata_o  = head.out_char;
  assign m_axis_tuser_o  = head.last_in_run;
  assign m_axis_tlast_o  = head.end_of_text;

  a_pend_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == (bl_q != 3'd0))
    else $error("pending flag disagrees with remaining byte count");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && text_end) |=> (!pend_q && acc_q == '0 && sm_q == u2l_pkg::SM_NONE))
    else $error("decode state not cleared after end of text");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && text_end) |=> m_axis_tvalid_o)
    else $error("end of text produced no result");

endmodule

>>> verif/utf8_to_latin1_decoder_tb.sv
// Self-checking testbench for the UTF-8 to Latin-1 decoder: directed and random byte streams.
`timescale 1ns / 1ps

module utf8_to_latin1_decoder_tb;

  localparam int unsigned CYCLE_LIMIT = 500000;

  // Directed bytes as {text_end, in_byte}
  localparam logic [8:0] DIRECTED [25] = '{
    {1'b0, 8'h41}, {1'b0, 8'h00}, {1'b0, 8'h7F},
    {1'b0, 8'hC3}, {1'b0, 8'hA9}, {1'b0, 8'hDF}, {1'b0, 8'hBF},
    {1'b0, 8'hE2}, {1'b0, 8'h80}, {1'b0, 8'h9C},
    {1'b0, 8'hE2}, {1'b0, 8'h80}, {1'b0, 8'h9D},
    {1'b0, 8'hE2}, {1'b0, 8'h80}, {1'b0, 8'h99},
    {1'b0, 8'hE2}, {1'b0, 8'h82}, {1'b0, 8'hAC},
    {1'b0, 8'hE2}, {1'b0, 8'h80}, {1'b0, 8'h41},
    {1'b0, 8'hBF}, {1'b0, 8'h41}, {1'b1, 8'hFF}
  };

  // Decode state mirror and the queue of characters still owed by the block
  class latin1_scoreboard;
    u2l_pkg::result_t pending_chars[$];
    logic [7:0]  repl_char;
    logic [30:0] code_acc;
    logic [2:0]  bytes_left;
    logic        char_open;
    logic [1:0]  triple_state;
    int          mismatches;

    function new();
      repl_char  = u2l_pkg::REPL_RESET;
      mismatches = 0;
      clear_char();
    endfunction

    function void clear_char();
      code_acc     = '0;
      bytes_left   = '0;
      char_open    = 1'b0;
      triple_state = u2l_pkg::SM_NONE;
    endfunction

    function logic [7:0] plain_value();
      return (code_acc <= 31'd255) ? code_acc[7:0] : repl_char;
    endfunction

    function int outstanding();
      return pending_chars.size();
    endfunction

    // Predict the characters caused by one accepted byte
    function void note_byte(input logic [7:0] b, input logic fin);
      logic [7:0] made[$];
      logic [1:0] prev_state;
      logic [7:0] c;
      logic [7:0] msk;
      logic [2:0] len;
      u2l_pkg::result_t r;
      if (char_open && b[7:6] == 2'b10) begin
        prev_state = triple_state;
        code_acc   = {code_acc[24:0], b[5:0]};
        bytes_left = bytes_left - 3'd1;
        if (prev_state == u2l_pkg::SM_E2)
          triple_state = (b == u2l_pkg::CONT_80) ? u2l_pkg::SM_E2_80 :
                         (b == u2l_pkg::CONT_82) ? u2l_pkg::SM_E2_82 : u2l_pkg::SM_NONE;
        else
          triple_state = u2l_pkg::SM_NONE;
        if (bytes_left == 3'd0) begin
          c = plain_value();
          if (prev_state == u2l_pkg::SM_E2_80 && b == u2l_pkg::CONT_9C)
            c = u2l_pkg::CHAR_LDQUO;
          else if (prev_state == u2l_pkg::SM_E2_80 && b == u2l_pkg::CONT_9D)
            c = u2l_pkg::CHAR_RDQUO;
          else if (prev_state == u2l_pkg::SM_E2_80 && b == u2l_pkg::CONT_99)
            c = u2l_pkg::CHAR_RSQUO;
          else if (prev_state == u2l_pkg::SM_E2_82 && b == u2l_pkg::CONT_AC)
            c = u2l_pkg::CHAR_CURRENCY;
          made.push_back(c);
          clear_char();
        end
      end else begin
        // A non-continuation byte closes any open character first
        if (char_open) begin
          made.push_back(plain_value());
          clear_char();
        end
        casez (b)
          8'b0???????: begin len = 3'd1; msk = 8'h7F; end
          8'b10??????: begin len = 3'd5; msk = 8'h3F; end
          8'b110?????: begin len = 3'd2; msk = 8'h1F; end
          8'b1110????: begin len = 3'd3; msk = 8'h0F; end
          8'b11110???: begin len = 3'd4; msk = 8'h07; end
          8'b111110??: begin len = 3'd5; msk = 8'h03; end
          default:     begin len = 3'd6; msk = 8'h01; end
        endcase
        code_acc     = {23'd0, b & msk};
        bytes_left   = len - 3'd1;
        char_open    = 1'b1;
        triple_state = (b == u2l_pkg::LEAD_E2) ? u2l_pkg::SM_E2 : u2l_pkg::SM_NONE;
        if (bytes_left == 3'd0) begin
          made.push_back(plain_value());
          clear_char();
        end
      end
      if (fin) begin
        if (char_open) made.push_back(plain_value());
        clear_char();
      end
      foreach (made[i]) begin
        r.out_char    = made[i];
        r.last_in_run = (i == made.size() - 1);
        r.end_of_text = fin && (i == made.size() - 1);
        pending_chars.push_back(r);
      end
    endfunction

    task report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_char(input logic [7:0] c, input logic last, input logic eot);
      u2l_pkg::result_t want;
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected character", c, 0);
      end else begin
        want = pending_chars.pop_front();
        if (c !== want.out_char) report_mismatch("out_char", c, want.out_char);
        if (last !== want.last_in_run) report_mismatch("last_in_run", last, want.last_in_run);
        if (eot !== want.end_of_text) report_mismatch("end_of_text", eot, want.end_of_text);
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_wdata_i = '0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = '0;
  logic       s_axis_tlast_i = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tuser_o;
  logic       m_axis_tlast_o;

  latin1_scoreboard board = new();
  bit quiet = 1'b0;
  int bytes_sent = 0;
  int cycles = 0;

  utf8_to_latin1_decoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none while quiet
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic pick_end();
    return ($urandom_range(0, 31) == 0);
  endfunction

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] lead_for_len(input int n);
    case (n)
      2:       return 8'($urandom_range(8'hC0, 8'hDF));
      3:       return 8'($urandom_range(8'hE0, 8'hEF));
      4:       return 8'($urandom_range(8'hF0, 8'hF7));
      5:       return 8'($urandom_range(8'hF8, 8'hFB));
      default: return 8'($urandom_range(8'hFC, 8'hFF));
    endcase
  endfunction

  // Output side: check accepted characters and stall at random
  initial begin : sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        board.check_char(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        stall--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Offer one byte, hold it until the request is taken, then maybe pause
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_byte(b, fin);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_seq(input logic [7:0] lead, input int ncont);
    send_byte(lead, pick_end());
    repeat (ncont) send_byte(rand_cont(), pick_end());
  endtask

  task automatic send_random_unit();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      send_byte(8'($urandom_range(1, 127)), pick_end());
    end else if (r < 50) begin
      send_seq(lead_for_len(2), 1);
    end else if (r < 60) begin
      send_seq(lead_for_len(3), 2);
    end else if (r < 70) begin
      // quote and currency triples, now and then with a wrong tail
      send_byte(u2l_pkg::LEAD_E2, pick_end());
      n = $urandom_range(0, 4);
      send_byte((n == 3) ? u2l_pkg::CONT_82 : u2l_pkg::CONT_80, pick_end());
      case (n)
        0:       send_byte(u2l_pkg::CONT_9C, pick_end());
        1:       send_byte(u2l_pkg::CONT_9D, pick_end());
        2:       send_byte(u2l_pkg::CONT_99, pick_end());
        3:       send_byte(u2l_pkg::CONT_AC, pick_end());
        default: send_byte(rand_cont(), pick_end());
      endcase
    end else if (r < 75) begin
      send_seq(lead_for_len(4), 3);
    end else if (r < 78) begin
      send_seq(lead_for_len(5), 4);
    end else if (r < 80) begin
      send_seq(lead_for_len(6), 5);
    end else if (r < 90) begin
      // truncated sequence, cut short by whatever comes next
      n = $urandom_range(2, 6);
      send_seq(lead_for_len(n), $urandom_range(0, n - 2));
    end else begin
      send_byte(8'($urandom_range(1, 255)), pick_end());
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_repl(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.repl_char = v;
    cfg_valid_i <= 1'b0;
  endtask

  // Random bytes, then close the text so no character stays open
  task automatic run_phase(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) send_random_unit();
    send_byte(8'($urandom_range(1, 127)), 1'b1);
    drain();
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    drain();

    write_repl(8'hFF);
    quiet = 1'b1;
    run_phase(380);
    quiet = 1'b0;

    write_repl(8'h00);
    run_phase(380);

    write_repl(8'($urandom_range(1, 254)));
    run_phase(380);

    write_repl(u2l_pkg::REPL_RESET);
    run_phase(380);

    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/u2l_pkg.sv
src/u2l_out_queue.sv
src/utf8_to_latin1_decoder.sv
verif/utf8_to_latin1_decoder_tb.sv
